// ===== hdl/bkj_pkg.sv =====
package bkj_pkg;

    localparam int DELAY_WIDTH = 16;

    // doubled delay needs one extra bit before the clamp
    localparam int DLY_W     = DELAY_WIDTH + 1;
    localparam int REM_W     = DELAY_WIDTH - 2;
    localparam int RNG_W     = 32;
    localparam int BIT_CNT_W = $clog2(RNG_W);
    localparam int ATT_W     = 8;
    localparam int OUT_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int REG_W     = 16;

    localparam logic [RNG_W-1:0] SEED_ZERO_SUB = 32'hA5A5A5A5;
    localparam int MAX_ZERO_SUB  = 30;
    localparam int BASE_RESET    = 1;
    localparam int SHIFT_A       = 13;
    localparam int SHIFT_B       = 17;
    localparam int SHIFT_C       = 5;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(RNG_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SEED = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOUBLE,
        ST_CLAMP,
        ST_MODULO,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic dbl;
        logic clamp;
        logic adv;
        logic mod_step;
        logic fin;
    } ctl_t;

    typedef struct packed {
        logic stop_dbl;
        logic range_zero;
        logic last_bit;
        logic out_free;
    } stat_t;

    function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] y;
        y = x;
        y = y ^ (y << SHIFT_A);
        y = y ^ (y >> SHIFT_B);
        y = y ^ (y << SHIFT_C);
        return y;
    endfunction

endpackage

// ===== hdl/bkj_rng.sv =====
module bkj_rng (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      seed_load,
    input  logic [bkj_pkg::RNG_W-1:0] seed_value,
    input  logic                      adv,
    output logic [bkj_pkg::RNG_W-1:0] rng_next
);
    import bkj_pkg::*;

    logic [RNG_W-1:0] rng_reg;

    assign rng_next = xorshift(rng_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg <= SEED_ZERO_SUB;
        end
        else if (seed_load)
        begin
            rng_reg <= (seed_value != '0) ? seed_value : SEED_ZERO_SUB;
        end
        else if (adv)
        begin
            rng_reg <= rng_next;
        end
    end

endmodule

// ===== hdl/bkj_dp.sv =====
module bkj_dp (
    input  logic                            clk,
    input  bkj_pkg::ctl_t                   ctl,
    input  logic [bkj_pkg::DELAY_WIDTH-1:0] base_delay,
    input  logic [bkj_pkg::DELAY_WIDTH-1:0] max_delay,
    input  logic [bkj_pkg::ATT_W-1:0]       attempt,
    input  logic [bkj_pkg::RNG_W-1:0]       rng_next,
    output logic                            stop_dbl,
    output logic                            range_zero,
    output logic                            last_bit,
    output logic [bkj_pkg::OUT_W-1:0]       result
);
    import bkj_pkg::*;

    logic [DLY_W-1:0]       delay_reg, delay_next;
    logic [DELAY_WIDTH-1:0] max_reg, max_next;
    logic [ATT_W-1:0]       cnt_reg, cnt_next;
    logic [RNG_W-1:0]       word_reg, word_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;

    // shared compare/subtract unit
    logic [DLY_W-1:0]       op_a, op_b;
    logic [DLY_W:0]         diff;
    logic                   ge;
    logic [DLY_W-1:0]       clamped;
    logic [DLY_W:0]         sum;

    always_comb
    begin
        if (ctl.mod_step)
        begin
            op_a = DLY_W'({rem_reg, word_reg[RNG_W-1]});
            op_b = DLY_W'(delay_reg[DELAY_WIDTH-1:2]);
        end
        else
        begin
            op_a = delay_reg;
            op_b = DLY_W'(max_reg);
        end
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = ~diff[DLY_W];
    end

    assign clamped    = ge ? DLY_W'(max_reg) : delay_reg;
    assign stop_dbl   = ge || (cnt_reg == '0);
    assign range_zero = (clamped[DLY_W-1:2] == '0);
    assign last_bit   = (bit_cnt_reg == LAST_BIT);
    assign sum        = {1'b0, delay_reg} + (DLY_W + 1)'(rem_reg);
    assign result     = OUT_W'(sum);

    always_comb
    begin
        delay_next   = delay_reg;
        max_next     = max_reg;
        cnt_next     = cnt_reg;
        word_next    = word_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        if (ctl.load)
        begin
            delay_next = (base_delay == '0) ? DLY_W'(BASE_RESET) : DLY_W'(base_delay);
            max_next   = (max_delay == '0) ? DELAY_WIDTH'(MAX_ZERO_SUB) : max_delay;
            cnt_next   = attempt;
        end
        if (ctl.dbl)
        begin
            delay_next = delay_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
        end
        if (ctl.clamp)
        begin
            delay_next   = clamped;
            rem_next     = '0;
            bit_cnt_next = '0;
        end
        if (ctl.adv)
        begin
            word_next = rng_next;
        end
        if (ctl.mod_step)
        begin
            // restoring remainder, one word bit per step
            rem_next     = ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
            word_next    = word_reg << 1;
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg   <= delay_next;
        max_reg     <= max_next;
        cnt_reg     <= cnt_next;
        word_reg    <= word_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
    end

endmodule

// ===== hdl/bkj_ctl.sv =====
module bkj_ctl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bkj_pkg::stat_t stat,
    output bkj_pkg::ctl_t  ctl
);
    import bkj_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DOUBLE;
                end
            end
            ST_DOUBLE:
            begin
                if (stat.stop_dbl)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                state_next = stat.range_zero ? ST_FINISH : ST_MODULO;
            end
            ST_MODULO:
            begin
                if (stat.last_bit)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            ST_DOUBLE:
            begin
                ctl.dbl = ~stat.stop_dbl;
            end
            ST_CLAMP:
            begin
                ctl.clamp = 1'b1;
                ctl.adv   = ~stat.range_zero;
            end
            ST_MODULO:
            begin
                ctl.mod_step = 1'b1;
            end
            ST_FINISH:
            begin
                ctl.fin = stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ===== hdl/backoff_delay_with_jitter.sv =====
// Exponential backoff delay with jitter. Each request carries a retry attempt
// count; the block doubles the base delay once per attempt (stopping at the
// maximum), clamps to the maximum, and when the delay is 4 or more adds the next
// xorshift32 word modulo delay/4. Once a request is accepted the block is busy
// through its doublings (n of them, n at most 16 here), the clamp, the 32-step
// restoring remainder loop over the random word (skipped when the delay is below
// 4), run on the one shared subtract/compare unit, and the finish state, and takes
// no new request until it is idle again. A result still waiting in the output
// register holds the block in its finish state until that result is taken.
// One request is worked on at a time; the result sits in an output register so
// the next request can start while it waits. Config writes are always taken; a
// seed write reloads the generator at once.
module backoff_delay_with_jitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bkj_pkg::ATT_W-1:0]     attempt,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bkj_pkg::OUT_W-1:0]     delay_secs,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bkj_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bkj_pkg::CFG_W-1:0]     cfg_data
);
    import bkj_pkg::*;

    logic [DELAY_WIDTH-1:0] base_reg, base_next;
    logic [DELAY_WIDTH-1:0] max_reg, max_next;
    logic                   seed_load;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_reg;
    logic [RNG_W-1:0]       rng_next;
    logic [OUT_W-1:0]       result;
    ctl_t                   ctl;
    stat_t                  stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_next = base_reg;
        max_next  = max_reg;
        seed_load = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE: base_next = DELAY_WIDTH'(cfg_data[REG_W-1:0]);
                REG_MAX:  max_next  = DELAY_WIDTH'(cfg_data[REG_W-1:0]);
                REG_SEED: seed_load = 1'b1;
                default:  seed_load = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= DELAY_WIDTH'(BASE_RESET);
            max_reg  <= DELAY_WIDTH'(MAX_ZERO_SUB);
        end
        else
        begin
            base_reg <= base_next;
            max_reg  <= max_next;
        end
    end

    bkj_rng u_rng (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_load  (seed_load),
        .seed_value (cfg_data),
        .adv        (ctl.adv),
        .rng_next   (rng_next)
    );

    bkj_dp u_dp (
        .clk        (clk),
        .ctl        (ctl),
        .base_delay (base_reg),
        .max_delay  (max_reg),
        .attempt    (attempt),
        .rng_next   (rng_next),
        .stop_dbl   (stat.stop_dbl),
        .range_zero (stat.range_zero),
        .last_bit   (stat.last_bit),
        .result     (result)
    );

    assign stat.out_free = ~out_valid_reg | out_ready;

    bkj_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin)
        begin
            out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign delay_secs = out_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block ready right after taking a request");

    a_no_ready_in_modulo: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mod_step |-> !in_ready && !ctl.fin)
        else $error("remainder step overlaps idle or finish");

    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> delay_secs != '0)
        else $error("zero delay delivered");

    a_fin_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin |-> !out_valid || out_ready)
        else $error("result overwrites a pending one");

endmodule
